// File: src/bmram_pkg.sv
package bmram_pkg;

   // field widths
   localparam int SAMPLE_BITS   = 12;
   localparam int COUNT_BITS    = 14;
   localparam int ACC_BITS      = SAMPLE_BITS + COUNT_BITS;
   localparam int GAIN_BITS     = 16;
   localparam int OFFSET_BITS   = 24;
   localparam int UNIT_BITS     = 16;
   localparam int VALUE_BITS    = 32;
   localparam int FRAC_BITS     = 16;
   localparam int CSR_DATA_BITS = 24;
   localparam int CSR_INDEX_BITS = 3;

   // reset values of the registers
   localparam int RESET_COUNT = 1000;
   localparam int RESET_GAIN  = 256;
   localparam int RESET_UNIT  = 256;

   // scaling datapath widths
   localparam int MGAIN_BITS = SAMPLE_BITS + 1 + GAIN_BITS;
   localparam int LIN_BITS   = ((MGAIN_BITS > OFFSET_BITS) ? MGAIN_BITS : OFFSET_BITS) + 1;
   localparam int PROD_BITS  = LIN_BITS + UNIT_BITS;
   localparam int Q_BITS     = PROD_BITS - FRAC_BITS;
   localparam int WIDE_BITS  = ((Q_BITS > VALUE_BITS) ? Q_BITS : VALUE_BITS) + 1;

   // divider iteration counter width
   localparam int ITER_BITS = $clog2(ACC_BITS);

   // microprogram store
   localparam int STEP_BITS = 3;

   typedef logic [SAMPLE_BITS-1:0]          sample_type;
   typedef logic [COUNT_BITS-1:0]           count_type;
   typedef logic [ACC_BITS-1:0]             acc_type;
   typedef logic [ITER_BITS-1:0]            iter_type;
   typedef logic signed [GAIN_BITS-1:0]     gain_type;
   typedef logic signed [OFFSET_BITS-1:0]   offset_type;
   typedef logic signed [UNIT_BITS-1:0]     unit_type;
   typedef logic signed [VALUE_BITS-1:0]    value_type;
   typedef logic [CSR_DATA_BITS-1:0]        csr_data_type;
   typedef logic [CSR_INDEX_BITS-1:0]       csr_index_type;
   typedef logic [STEP_BITS-1:0]            step_type;

   // register indexes
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_MODE   = 3'd0,
      REG_COUNT  = 3'd1,
      REG_GAIN   = 3'd2,
      REG_OFFSET = 3'd3,
      REG_UNIT   = 3'd4
   } reg_index_type;

   // datapath operations
   typedef enum logic [2:0] {
      UOP_NOP      = 3'd0,
      UOP_SAMPLE   = 3'd1,
      UOP_DIV_STEP = 3'd2,
      UOP_LEVEL    = 3'd3,
      UOP_MUL_GAIN = 3'd4,
      UOP_OFFSET   = 3'd5,
      UOP_MUL_UNIT = 3'd6,
      UOP_EMIT     = 3'd7
   } uop_type;

   // jump conditions
   typedef enum logic [2:0] {
      COND_NONE       = 3'd0,
      COND_BLOCK_OPEN = 3'd1,
      COND_DIV_BUSY   = 3'd2,
      COND_NO_RESULT  = 3'd3,
      COND_OUT_BUSY   = 3'd4
   } cond_type;

   localparam step_type STEP_SAMPLE   = 3'd0;
   localparam step_type STEP_DIVIDE   = 3'd1;
   localparam step_type STEP_LEVEL    = 3'd2;
   localparam step_type STEP_MUL_GAIN = 3'd3;
   localparam step_type STEP_OFFSET   = 3'd4;
   localparam step_type STEP_MUL_UNIT = 3'd5;
   localparam step_type STEP_EMIT     = 3'd6;

   typedef struct packed {
      uop_type  op;
      cond_type cond;
      step_type target;
      step_type next_step;
   } ucode_word_type;

   typedef struct packed {
      uop_type op;
   } ctrl_type;

   typedef struct packed {
      logic sample_valid;
      logic block_open;
      logic div_busy;
      logic no_result;
      logic out_busy;
   } status_type;

   typedef struct packed {
      logic       mode;
      count_type  count;
      gain_type   gain;
      offset_type offset;
      unit_type   unit;
   } cfg_type;

   typedef struct packed {
      value_type  value;
      sample_type level;
      sample_type bias;
      logic       saturated;
   } result_type;

   // microprogram: jump to target when the condition holds, else go to next_step
   function automatic ucode_word_type ucode_rom(input step_type step);
      ucode_word_type word;
      case (step)
         STEP_SAMPLE:   word = '{UOP_SAMPLE,   COND_BLOCK_OPEN, STEP_SAMPLE, STEP_DIVIDE};
         STEP_DIVIDE:   word = '{UOP_DIV_STEP, COND_DIV_BUSY,   STEP_DIVIDE, STEP_LEVEL};
         STEP_LEVEL:    word = '{UOP_LEVEL,    COND_NO_RESULT,  STEP_SAMPLE, STEP_MUL_GAIN};
         STEP_MUL_GAIN: word = '{UOP_MUL_GAIN, COND_NONE,       STEP_SAMPLE, STEP_OFFSET};
         STEP_OFFSET:   word = '{UOP_OFFSET,   COND_NONE,       STEP_SAMPLE, STEP_MUL_UNIT};
         STEP_MUL_UNIT: word = '{UOP_MUL_UNIT, COND_NONE,       STEP_SAMPLE, STEP_EMIT};
         STEP_EMIT:     word = '{UOP_EMIT,     COND_OUT_BUSY,   STEP_EMIT,   STEP_SAMPLE};
         default:       word = '{UOP_NOP,      COND_NONE,       STEP_SAMPLE, STEP_SAMPLE};
      endcase
      return word;
   endfunction

endpackage

// File: src/bmram_if.sv
interface bmram_req_if;
   import bmram_pkg::*;
   logic       valid;
   logic       ready;
   sample_type sample;
   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface bmram_rsp_if;
   import bmram_pkg::*;
   logic       valid;
   logic       ready;
   value_type  value;
   sample_type level;
   sample_type bias;
   logic       saturated;
   modport source (output valid, output value, output level, output bias, output saturated,
                   input ready);
   modport sink   (input valid, input value, input level, input bias, input saturated,
                   output ready);
endinterface

interface bmram_csr_if;
   import bmram_pkg::*;
   logic          valid;
   logic          ready;
   csr_index_type index;
   csr_data_type  data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// File: src/bmram_sequencer.sv
module bmram_sequencer (
   input  logic                   clock,
   input  logic                   reset,
   input  bmram_pkg::status_type  status,
   output bmram_pkg::ctrl_type    ctrl
);
   import bmram_pkg::*;

   step_type       step_ff, step_in;
   ucode_word_type word;
   logic           jump;

   assign word    = ucode_rom(step_ff);
   assign ctrl.op = word.op;

   always_comb begin
      case (word.cond)
         COND_NONE:       jump = 1'b0;
         COND_BLOCK_OPEN: jump = !status.sample_valid || status.block_open;
         COND_DIV_BUSY:   jump = status.div_busy;
         COND_NO_RESULT:  jump = status.no_result;
         COND_OUT_BUSY:   jump = status.out_busy;
         default:         jump = 1'b0;
      endcase
      step_in = jump ? word.target : word.next_step;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_SAMPLE;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

// File: src/bmram_datapath.sv
module bmram_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  bmram_pkg::ctrl_type    ctrl,
   input  bmram_pkg::cfg_type     cfg,
   input  logic                   restart,
   input  logic                   sample_valid,
   input  bmram_pkg::sample_type  sample,
   input  logic                   out_busy,
   output bmram_pkg::status_type  status,
   output bmram_pkg::result_type  result
);
   import bmram_pkg::*;

   localparam iter_type DIV_LAST = ITER_BITS'(ACC_BITS - 1);

   logic       phase_ff, phase_in;
   count_type  count_ff, count_in;
   acc_type    acc_ff, acc_in;
   sample_type bias_ff, bias_in;
   acc_type    quo_ff, quo_in;
   count_type  rem_ff, rem_in;
   iter_type   iter_ff, iter_in;
   sample_type level_ff, level_in;
   sample_type out_bias_ff, out_bias_in;
   logic signed [MGAIN_BITS-1:0] mgain_ff, mgain_in;
   logic signed [LIN_BITS-1:0]   lin_ff, lin_in;
   logic signed [PROD_BITS-1:0]  prod_ff, prod_in;

   count_type  len;
   logic       dev;
   sample_type term;
   acc_type    acc_sum;
   count_type  cnt_inc;
   logic       block_open;
   logic [COUNT_BITS:0] shifted;
   logic [COUNT_BITS:0] len_ext;
   logic [COUNT_BITS:0] rem_diff;
   logic       ge;

   logic signed [Q_BITS-1:0]    q;
   logic signed [WIDE_BITS-1:0] q_wide;
   logic [WIDE_BITS-VALUE_BITS:0] top_bits;
   logic       fits;

   // zero block length behaves as one
   assign len     = (cfg.count == '0) ? COUNT_BITS'(1) : cfg.count;
   assign dev     = cfg.mode && phase_ff;
   assign term    = !dev ? sample :
                    (sample > bias_ff) ? sample - bias_ff : bias_ff - sample;
   assign acc_sum = acc_ff + ACC_BITS'(term);
   assign cnt_inc = count_ff + COUNT_BITS'(1);
   assign block_open = (cnt_inc != '0) && (cnt_inc < len);

   // one restoring division step
   assign shifted  = {rem_ff, quo_ff[ACC_BITS-1]};
   assign len_ext  = {1'b0, len};
   assign ge       = shifted >= len_ext;
   assign rem_diff = shifted - len_ext;

   always_comb begin
      phase_in    = phase_ff;
      count_in    = count_ff;
      acc_in      = acc_ff;
      bias_in     = bias_ff;
      quo_in      = quo_ff;
      rem_in      = rem_ff;
      iter_in     = iter_ff;
      level_in    = level_ff;
      out_bias_in = out_bias_ff;
      mgain_in    = mgain_ff;
      lin_in      = lin_ff;
      prod_in     = prod_ff;
      case (ctrl.op)
         UOP_SAMPLE: begin
            if (sample_valid) begin
               if (block_open) begin
                  acc_in   = acc_sum;
                  count_in = cnt_inc;
               end else begin
                  acc_in   = '0;
                  count_in = '0;
                  quo_in   = acc_sum;
                  rem_in   = '0;
                  iter_in  = '0;
               end
            end
         end
         UOP_DIV_STEP: begin
            rem_in  = ge ? rem_diff[COUNT_BITS-1:0] : shifted[COUNT_BITS-1:0];
            quo_in  = {quo_ff[ACC_BITS-2:0], ge};
            iter_in = iter_ff + ITER_BITS'(1);
         end
         UOP_LEVEL: begin
            level_in = quo_ff[SAMPLE_BITS-1:0];
            if (!cfg.mode) begin
               phase_in    = 1'b0;
               out_bias_in = quo_ff[SAMPLE_BITS-1:0];
            end else if (!phase_ff) begin
               bias_in  = quo_ff[SAMPLE_BITS-1:0];
               phase_in = 1'b1;
            end else begin
               phase_in    = 1'b0;
               out_bias_in = bias_ff;
            end
         end
         UOP_MUL_GAIN: mgain_in = $signed({1'b0, level_ff}) * $signed(cfg.gain);
         UOP_OFFSET:   lin_in = LIN_BITS'(mgain_ff) + LIN_BITS'($signed(cfg.offset));
         UOP_MUL_UNIT: prod_in = lin_ff * $signed(cfg.unit);
         default: ;
      endcase
      // mode or length rewrite drops the block in progress
      if (restart) begin
         phase_in = 1'b0;
         count_in = '0;
         acc_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 1'b0;
         count_ff <= '0;
         acc_ff   <= '0;
         bias_ff  <= '0;
         iter_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         acc_ff   <= acc_in;
         bias_ff  <= bias_in;
         iter_ff  <= iter_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      level_ff    <= level_in;
      out_bias_ff <= out_bias_in;
      mgain_ff    <= mgain_in;
      lin_ff      <= lin_in;
      prod_ff     <= prod_in;
   end

   // floor shift then clip to the value range
   assign q        = Q_BITS'(prod_ff >>> FRAC_BITS);
   assign q_wide   = WIDE_BITS'(q);
   assign top_bits = q_wide[WIDE_BITS-1:VALUE_BITS-1];
   assign fits     = (&top_bits) || !(|top_bits);

   always_comb begin
      if (fits) begin
         result.value = q_wide[VALUE_BITS-1:0];
      end else if (q_wide[WIDE_BITS-1]) begin
         result.value = {1'b1, {(VALUE_BITS-1){1'b0}}};
      end else begin
         result.value = {1'b0, {(VALUE_BITS-1){1'b1}}};
      end
      result.level     = level_ff;
      result.bias      = out_bias_ff;
      result.saturated = !fits;
   end

   assign status.sample_valid = sample_valid;
   assign status.block_open   = block_open;
   assign status.div_busy     = iter_ff != DIV_LAST;
   assign status.no_result    = cfg.mode && !phase_ff;
   assign status.out_busy     = out_busy;

endmodule

// File: src/block_mean_and_rectified_average_meter_unit.sv
// channel   dir  payload                                   transfer
// req_chan  in   sample[11:0]                              valid && ready
// rsp_chan  out  value[31:0] level[11:0] bias[11:0] sat    valid && ready
// csr_chan  in   index[2:0] data[23:0]                     valid && ready (always ready)
//
// a sample inside a block is taken in the sampling step; the sample that closes a block is followed
// by a restoring divide, so a block end holds req_chan off through the divide and the level step
// (ac bias block) or through those, the scaling steps and any wait on rsp_chan (result block)
// synchronous active-high reset restores the register defaults and clears the block
// the result sits in an output register, so samples keep flowing while it waits
module block_mean_and_rectified_average_meter_unit (
   input logic       clock,
   input logic       reset,
   bmram_req_if.sink   req_chan,
   bmram_rsp_if.source rsp_chan,
   bmram_csr_if.sink   csr_chan
);
   import bmram_pkg::*;

   // configuration registers
   cfg_type cfg_ff, cfg_in;
   logic    restart;

   // output register
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_data_ff, rsp_data_in;

   ctrl_type   ctrl;
   status_type status;
   result_type result;
   logic       out_busy;
   logic       load;
   logic       csr_write;

   assign csr_chan.ready = 1'b1;
   assign csr_write      = csr_chan.valid && csr_chan.ready;

   always_comb begin
      cfg_in  = cfg_ff;
      restart = 1'b0;
      if (csr_write) begin
         case (csr_chan.index)
            REG_MODE: begin
               cfg_in.mode = csr_chan.data[0];
               restart     = 1'b1;
            end
            REG_COUNT: begin
               cfg_in.count = csr_chan.data[COUNT_BITS-1:0];
               restart      = 1'b1;
            end
            REG_GAIN:   cfg_in.gain   = csr_chan.data[GAIN_BITS-1:0];
            REG_OFFSET: cfg_in.offset = csr_chan.data[OFFSET_BITS-1:0];
            REG_UNIT:   cfg_in.unit   = csr_chan.data[UNIT_BITS-1:0];
            default: ;  // writes past the register list are dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode   <= 1'b0;
         cfg_ff.count  <= COUNT_BITS'(RESET_COUNT);
         cfg_ff.gain   <= GAIN_BITS'(RESET_GAIN);
         cfg_ff.offset <= '0;
         cfg_ff.unit   <= UNIT_BITS'(RESET_UNIT);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // samples are taken only in the sampling step of the microprogram
   assign req_chan.ready = (ctrl.op == UOP_SAMPLE);

   // output register is blocked while a result waits unaccepted
   assign out_busy = rsp_valid_ff && !rsp_chan.ready;
   assign load     = (ctrl.op == UOP_EMIT) && !out_busy;

   always_comb begin
      rsp_data_in = rsp_data_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.value     = rsp_data_ff.value;
   assign rsp_chan.level     = rsp_data_ff.level;
   assign rsp_chan.bias      = rsp_data_ff.bias;
   assign rsp_chan.saturated = rsp_data_ff.saturated;

   // step counter and control store
   bmram_sequencer u_sequencer (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   // accumulator, divider and scaling chain
   bmram_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .ctrl         (ctrl),
      .cfg          (cfg_ff),
      .restart      (restart),
      .sample_valid (req_chan.valid),
      .sample       (req_chan.sample),
      .out_busy     (out_busy),
      .status       (status),
      .result       (result)
   );

endmodule
